/* rtl/at_code_text_cell_parser_assert.svh */
// Assertion helpers for the checker file.
`ifndef AT_CODE_TEXT_CELL_PARSER_ASSERT_SVH
`define AT_CODE_TEXT_CELL_PARSER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define ATCTP_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("at_code_text_cell_parser: port check failed");

// Next-cycle implication, masked while reset is high.
`define ATCTP_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("at_code_text_cell_parser: port check failed");

// Next-cycle implication that also covers the reset cycles.
`define ATCTP_ASSERT_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("at_code_text_cell_parser: reset check failed");

`endif

/* rtl/atctp_pkg.sv */
package atctp_pkg;

  localparam int COL_LIMIT        = 1023;
  localparam int ROW_LIMIT        = 65535;
  localparam int TAB_STEP_DEFAULT = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam int COL_W   = $clog2(COL_LIMIT + 1);
  localparam int ROW_W   = $clog2(ROW_LIMIT + 1);
  localparam int TDATA_W = 56;

  // scan window: longest code is @POS:nn@
  localparam int WIN_DEPTH = 8;

  localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
  localparam logic [7:0] BACK_RESET       = 8'd0;
  localparam logic [7:0] FORE_RESET       = 8'd7;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SUB   = 8'd26;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_AT    = 8'd64;
  localparam logic [7:0] CH_C     = 8'd67;
  localparam logic [7:0] CH_L     = 8'd76;
  localparam logic [7:0] CH_O     = 8'd79;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_S     = 8'd83;
  localparam logic [7:0] CH_X     = 8'd88;

  typedef enum logic [2:0] {
    OP_PLAIN,
    OP_COLOR,
    OP_CLS,
    OP_POS,
    OP_EXTENT,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       arg0;
    logic [7:0]       arg1;
    logic [COL_W-1:0] col;
    logic             last;
  } op_t;

  typedef struct packed {
    logic           kind;
    logic [COL_W:0] col;
    logic [ROW_W:0] row;
    logic [7:0]     back;
    logic [7:0]     fore;
    logic [7:0]     glyph;
    logic           eor;
  } result_t;

  typedef enum logic [1:0] {
    FS_FEED,
    FS_FLUSH,
    FS_EXTENT
  } front_state_t;

endpackage

/* rtl/atctp_queue.sv */
module atctp_queue #(
  parameter int DEPTH = atctp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  atctp_pkg::op_t    in_op,
  output logic              out_valid,
  input  logic              out_ready,
  output atctp_pkg::op_t    out_op
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  atctp_pkg::op_t    entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_op    = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_op;
    end
  end

endmodule

/* rtl/atctp_front.sv */
module atctp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_final,
  output logic            op_valid,
  input  logic            op_ready,
  output atctp_pkg::op_t  op
);

  localparam int WD     = atctp_pkg::WIN_DEPTH;
  localparam int FILL_W = $clog2(WD + 1);
  localparam int PEND_W = $clog2(WD);
  localparam int POS_W  = 13;

  typedef enum logic [1:0] {
    SCAN_WAIT,
    SCAN_DONE,
    SCAN_FAIL,
    SCAN_DONE_KEEP
  } scan_t;

  atctp_pkg::front_state_t state, state_next;

  // win holds held prefix bytes [0..pcnt-1] followed by bytes still to rescan
  logic [WD-1:0][7:0] win, win_next, cw;
  logic [PEND_W-1:0]  pcnt, pcnt_next;
  logic [FILL_W-1:0]  fill, fill_next, fill_after, shift, len;
  logic               fin_pend, fin_next, fin_now;
  logic               has_work, take, active;
  scan_t              st;
  atctp_pkg::op_t     code_op, op_out;
  logic               op_push;

  logic signed [POS_W-1:0] d5, pos_raw;
  logic [atctp_pkg::COL_W-1:0] pos_col;

  function automatic scan_t classify(logic [WD-1:0][7:0] s, logic [FILL_W-1:0] n);
    scan_t r;
    r = SCAN_FAIL;
    if (n < FILL_W'(2)) begin
      r = SCAN_WAIT;
    end else if (s[1] == atctp_pkg::CH_X) begin
      r = (n >= FILL_W'(4)) ? SCAN_DONE : SCAN_WAIT;
    end else if (s[1] == atctp_pkg::CH_C) begin
      if (n > FILL_W'(2) && s[2] != atctp_pkg::CH_L) begin
        r = SCAN_FAIL;
      end else if (n > FILL_W'(3) && s[3] != atctp_pkg::CH_S) begin
        r = SCAN_FAIL;
      end else begin
        r = (n >= FILL_W'(5)) ? SCAN_DONE : SCAN_WAIT;
      end
    end else if (s[1] == atctp_pkg::CH_P) begin
      if (n > FILL_W'(2) && s[2] != atctp_pkg::CH_O) begin
        r = SCAN_FAIL;
      end else if (n > FILL_W'(3) && s[3] != atctp_pkg::CH_S) begin
        r = SCAN_FAIL;
      end else if (n > FILL_W'(4) && s[4] != atctp_pkg::CH_COLON) begin
        r = SCAN_FAIL;
      end else if (n < FILL_W'(7)) begin
        r = SCAN_WAIT;
      end else if (s[6] == atctp_pkg::CH_AT) begin
        r = SCAN_DONE;
      end else if (n < FILL_W'(8)) begin
        r = SCAN_WAIT;
      end else begin
        r = (s[7] == atctp_pkg::CH_AT) ? SCAN_DONE : SCAN_DONE_KEEP;
      end
    end
    return r;
  endfunction

  assign has_work = (fill != FILL_W'(pcnt));
  assign in_ready = (state == atctp_pkg::FS_FEED) && !has_work && op_ready;
  assign take     = in_valid && in_ready;
  assign active   = (state == atctp_pkg::FS_FEED) && op_ready && (has_work || in_valid);
  assign fin_now  = fin_pend || (take && in_final);
  assign len      = FILL_W'(pcnt) + 1'b1;

  // byte under scan sits at pcnt: from the window when rescanning, else the request
  always_comb begin
    cw = win;
    for (int i = 0; i < WD; i++) begin
      if (!has_work && PEND_W'(i) == pcnt) begin
        cw[i] = in_byte;
      end
    end
  end

  assign st = classify(cw, len);

  // POS column: one digit ends in '@' at s[6], else two digits
  always_comb begin
    d5 = $signed({5'd0, cw[5]}) - $signed({5'd0, atctp_pkg::CH_ZERO});
    if (cw[6] == atctp_pkg::CH_AT) begin
      pos_raw = d5 - POS_W'(1);
    end else begin
      pos_raw = (d5 <<< 3) + (d5 <<< 1) + $signed({5'd0, cw[6]})
                - $signed({5'd0, atctp_pkg::CH_ZERO}) - POS_W'(1);
    end
    if (pos_raw < 0) begin
      pos_col = '0;
    end else if (pos_raw > $signed(POS_W'(atctp_pkg::COL_LIMIT))) begin
      pos_col = atctp_pkg::COL_W'(atctp_pkg::COL_LIMIT);
    end else begin
      pos_col = pos_raw[atctp_pkg::COL_W-1:0];
    end
  end

  always_comb begin
    code_op      = '{kind: atctp_pkg::OP_POS, arg0: cw[2], arg1: cw[3], col: pos_col,
                     last: 1'b0};
    if (cw[1] == atctp_pkg::CH_X) begin
      code_op.kind = atctp_pkg::OP_COLOR;
    end else if (cw[1] == atctp_pkg::CH_C) begin
      code_op.kind = atctp_pkg::OP_CLS;
    end
  end

  always_comb begin
    state_next = state;
    pcnt_next  = pcnt;
    fill_next  = fill;
    win_next   = win;
    fin_next   = fin_pend;
    shift      = '0;
    fill_after = fill;
    op_push    = 1'b0;
    op_out     = '{kind: atctp_pkg::OP_END, arg0: 8'd0, arg1: 8'd0, col: '0, last: 1'b0};
    case (state)
      atctp_pkg::FS_FEED: begin
        if (active) begin
          if (pcnt == '0) begin
            if (cw[0] == atctp_pkg::CH_AT) begin
              pcnt_next = PEND_W'(1);
            end else begin
              op_out.kind = atctp_pkg::OP_PLAIN;
              op_out.arg0 = cw[0];
              op_push     = 1'b1;
              shift       = FILL_W'(1);
            end
          end else begin
            case (st)
              SCAN_WAIT: begin
                pcnt_next = pcnt + 1'b1;
              end
              SCAN_DONE: begin
                op_out    = code_op;
                op_push   = 1'b1;
                shift     = len;
                pcnt_next = '0;
              end
              SCAN_DONE_KEEP: begin
                // last byte is not part of the code: rescan it
                op_out    = code_op;
                op_push   = 1'b1;
                shift     = len - 1'b1;
                pcnt_next = '0;
              end
              default: begin
                // failed prefix: draw the '@', rescan everything after it
                op_out.kind = atctp_pkg::OP_PLAIN;
                op_out.arg0 = cw[0];
                op_push     = 1'b1;
                shift       = FILL_W'(1);
                pcnt_next   = '0;
              end
            endcase
          end
          fill_after = fill + FILL_W'(take) - shift;
          fill_next  = fill_after;
          win_next   = cw >> {shift, 3'b000};
          if (fill_after == FILL_W'(pcnt_next)) begin
            fin_next = 1'b0;
            if (fin_now) begin
              state_next = (pcnt_next != '0) ? atctp_pkg::FS_FLUSH : atctp_pkg::FS_EXTENT;
            end else begin
              op_out.last = 1'b1;
              op_push     = 1'b1;
            end
          end else begin
            fin_next = fin_now;
          end
        end
      end
      atctp_pkg::FS_FLUSH: begin
        if (op_ready) begin
          op_out.kind = atctp_pkg::OP_PLAIN;
          op_out.arg0 = win[0];
          op_push     = 1'b1;
          win_next    = win >> 8;
          pcnt_next   = pcnt - 1'b1;
          fill_next   = fill - 1'b1;
          if (pcnt == PEND_W'(1)) begin
            state_next = atctp_pkg::FS_EXTENT;
          end
        end
      end
      atctp_pkg::FS_EXTENT: begin
        if (op_ready) begin
          op_out.kind = atctp_pkg::OP_EXTENT;
          op_out.last = 1'b1;
          op_push     = 1'b1;
          pcnt_next   = '0;
          fill_next   = '0;
          state_next  = atctp_pkg::FS_FEED;
        end
      end
      default: begin
        state_next = atctp_pkg::FS_FEED;
      end
    endcase
  end

  assign op_valid = op_push;
  assign op       = op_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= atctp_pkg::FS_FEED;
      pcnt     <= '0;
      fill     <= '0;
      fin_pend <= 1'b0;
    end else begin
      state    <= state_next;
      pcnt     <= pcnt_next;
      fill     <= fill_next;
      fin_pend <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

endmodule

/* rtl/atctp_back.sv */
module atctp_back #(
  parameter int TAB_STEP = atctp_pkg::TAB_STEP_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                op_valid,
  output logic                op_ready,
  input  atctp_pkg::op_t      op,
  output logic                res_valid,
  input  logic                res_ready,
  output atctp_pkg::result_t  res
);

  localparam int COL_W = atctp_pkg::COL_W;
  localparam int ROW_W = atctp_pkg::ROW_W;

  logic [7:0]       line_width;
  logic [COL_W-1:0] col, col_next, col1, widest, widest_next;
  logic [ROW_W-1:0] row, row_next, row1, deepest, deepest_next;
  logic [7:0]       cur_back, cur_back_next, cur_fore, cur_fore_next;
  logic             stopped, stopped_next;
  logic [8:0]       wrap_w;
  logic             at_wrap;

  logic               consume, gen, can_move, move;
  atctp_pkg::result_t res_new;
  atctp_pkg::result_t hold, hold_next, out_res, out_res_next;
  logic               hold_v, hold_v_next, hold_closed, hold_closed_next;
  logic               out_v, out_v_next;

  function automatic logic [ROW_W-1:0] row_step(logic [ROW_W-1:0] r);
    return (r == ROW_W'(atctp_pkg::ROW_LIMIT)) ? r : r + 1'b1;
  endfunction

  function automatic logic [COL_W-1:0] col_clamp(logic [COL_W:0] v);
    return (v > (COL_W + 1)'(atctp_pkg::COL_LIMIT)) ? COL_W'(atctp_pkg::COL_LIMIT)
                                                     : v[COL_W-1:0];
  endfunction

  // a zero width wraps at 256
  assign wrap_w  = (line_width == '0) ? 9'd256 : {1'b0, line_width};
  assign at_wrap = (col == COL_W'(wrap_w));
  assign col1    = at_wrap ? '0 : col;
  assign row1    = at_wrap ? row_step(row) : row;

  assign can_move = hold_v && (!out_v || res_ready);
  assign op_ready = !hold_v || can_move;
  assign consume  = op_valid && op_ready;
  assign move     = can_move && (hold_closed || (consume && gen));

  always_comb begin
    col_next      = col;
    row_next      = row;
    widest_next   = widest;
    deepest_next  = deepest;
    cur_back_next = cur_back;
    cur_fore_next = cur_fore;
    stopped_next  = stopped;
    gen           = 1'b0;
    res_new       = '{kind: 1'b0, col: {1'b0, col1}, row: {1'b0, row1}, back: cur_back,
                      fore: cur_fore, glyph: op.arg0, eor: op.last};
    if (consume && (!stopped || op.kind == atctp_pkg::OP_EXTENT)) begin
      case (op.kind)
        atctp_pkg::OP_PLAIN: begin
          col_next = col1;
          row_next = row1;
          case (op.arg0)
            atctp_pkg::CH_LF: begin
              col_next = '0;
              row_next = row_step(row1);
            end
            atctp_pkg::CH_CR: begin
            end
            atctp_pkg::CH_TAB: begin
              col_next = col_clamp({1'b0, col1} + (COL_W + 1)'(TAB_STEP));
            end
            atctp_pkg::CH_SUB: begin
              stopped_next = 1'b1;
            end
            default: begin
              if (col1 > widest) widest_next = col1;
              if (row1 > deepest) deepest_next = row1;
              gen      = 1'b1;
              col_next = col_clamp({1'b0, col1} + 1'b1);
            end
          endcase
        end
        atctp_pkg::OP_COLOR: begin
          col_next      = col1;
          row_next      = row1;
          cur_back_next = op.arg0;
          cur_fore_next = op.arg1;
        end
        atctp_pkg::OP_CLS: begin
          col_next     = '0;
          row_next     = '0;
          widest_next  = '0;
          deepest_next = '0;
        end
        atctp_pkg::OP_POS: begin
          row_next = row1;
          col_next = op.col;
        end
        atctp_pkg::OP_EXTENT: begin
          gen           = 1'b1;
          res_new.kind  = 1'b1;
          res_new.col   = {1'b0, widest} + 1'b1;
          res_new.row   = {1'b0, deepest} + 1'b1;
          res_new.back  = 8'd0;
          res_new.fore  = 8'd0;
          res_new.glyph = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // hold keeps the newest result until we know whether it ends the run
  always_comb begin
    hold_next        = hold;
    hold_v_next      = hold_v;
    hold_closed_next = hold_closed;
    out_res_next     = out_res;
    out_v_next       = out_v;
    if (move) begin
      out_v_next       = 1'b1;
      out_res_next     = hold;
      hold_v_next      = 1'b0;
      hold_closed_next = 1'b0;
    end else if (res_ready) begin
      out_v_next = 1'b0;
    end
    if (consume && gen) begin
      hold_next        = res_new;
      hold_v_next      = 1'b1;
      hold_closed_next = op.last;
    end else if (consume && op.last && hold_v && !move) begin
      hold_next.eor    = 1'b1;
      hold_closed_next = 1'b1;
    end
  end

  assign res_valid = out_v;
  assign res       = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= atctp_pkg::LINE_WIDTH_RESET;
      col         <= '0;
      row         <= '0;
      widest      <= '0;
      deepest     <= '0;
      cur_back    <= atctp_pkg::BACK_RESET;
      cur_fore    <= atctp_pkg::FORE_RESET;
      stopped     <= 1'b0;
      hold_v      <= 1'b0;
      hold_closed <= 1'b0;
      out_v       <= 1'b0;
    end else begin
      if (cfg_wr_en) line_width <= cfg_wr_data;
      col         <= col_next;
      row         <= row_next;
      widest      <= widest_next;
      deepest     <= deepest_next;
      cur_back    <= cur_back_next;
      cur_fore    <= cur_fore_next;
      stopped     <= stopped_next;
      hold_v      <= hold_v_next;
      hold_closed <= hold_closed_next;
      out_v       <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    hold    <= hold_next;
    out_res <= out_res_next;
  end

endmodule

/* rtl/at_code_text_cell_parser.sv */
// Channel   Dir  tdata fields (low bit up)                          tuser  tlast
// s_axis    in   text_byte[7:0]                                     -      final_byte
// m_axis    out  cell_column[10:0] cell_row[27:11] back_colour[35:28]
//                fore_colour[43:36] glyph[51:44] zero[55:52]        kind   end_of_run
// cfg       in   cfg_wr_data = line_width, written when cfg_wr_en is high
//
// One input byte per cycle while nothing is rescanned or flushed and the op queue
// has room; a failed prefix draws its '@' and rescans the bytes after it, and an
// @POS:nn code with no closing @ rescans the byte after it. A final byte flushes the
// held bytes as plain characters, then the extent report. The back end runs one op
// per cycle unless m_axis stalls it. Reset is synchronous; there is no clearing pass.
// The op queue (QUEUE_DEPTH entries) lets the scanner run ahead while m_axis stalls.
module at_code_text_cell_parser #(
  parameter int TAB_STEP    = atctp_pkg::TAB_STEP_DEFAULT,
  parameter int QUEUE_DEPTH = atctp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // text_byte
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [atctp_pkg::TDATA_W-1:0] m_axis_tdata,   // cell_column, cell_row,
                                                        // back_colour, fore_colour, glyph
  output logic                          m_axis_tuser,   // kind
  output logic                          m_axis_tlast
);

  localparam int PAD_W = atctp_pkg::TDATA_W - (atctp_pkg::COL_W + 1)
                         - (atctp_pkg::ROW_W + 1) - 24;

  atctp_pkg::op_t     fq_op, qb_op;
  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  atctp_pkg::result_t res;

  atctp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_final (s_axis_tlast),
    .op_valid (fq_valid),
    .op_ready (fq_ready),
    .op       (fq_op)
  );

  atctp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_op     (fq_op),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_op    (qb_op)
  );

  atctp_back #(
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_valid    (qb_valid),
    .op_ready    (qb_ready),
    .op          (qb_op),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tdata = {PAD_W'(0), res.glyph, res.fore, res.back, res.row, res.col};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.eor;

endmodule

/* rtl/atctp_checker.sv */
`include "at_code_text_cell_parser_assert.svh"

module atctp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [atctp_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  // stalled result request holds
  `ATCTP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // extent report closes the run of its byte and carries no colours or glyph
  `ATCTP_ASSERT_IMP(a_extent_form, m_axis_tvalid && m_axis_tuser, m_axis_tlast && m_axis_tdata[51:28] == 24'd0)

  // character cells stay inside the column range; pad bits are zero
  `ATCTP_ASSERT_IMP(a_cell_col, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[10:0] <= 11'(atctp_pkg::COL_LIMIT) && m_axis_tdata[55:52] == 4'd0)

  // the flush after a final byte keeps s_axis_tready low in the next cycle
  `ATCTP_ASSERT_NXT(a_final_flush, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

  // no result right after reset
  `ATCTP_ASSERT_RST(a_reset_idle, rst, !m_axis_tvalid)

endmodule

bind at_code_text_cell_parser atctp_checker u_atctp_checker (.*);
